// File: rtl/nncl_pkg.sv
// Shared types and constants for the nearest-neighbour-chain clustering unit.
// Item structs, datapath op codes, controller states and the status bundle.
// No dependencies.
`default_nettype none

package nncl_pkg;

	localparam int DIST_W = 16;
	localparam int PT_W = 6;
	localparam int CFG_W = 7;
	localparam int PC_RESET = 64;
	// chain is reused only when more entries than this remain on it
	localparam int REUSE_DEPTH = 3;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              last_distance;
	} dist_item_t;

	typedef struct packed {
		logic [PT_W-1:0]   first_point;
		logic [PT_W-1:0]   second_point;
		logic [DIST_W-1:0] merge_distance;
		logic              final_merge;
	} merge_item_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_INIT,
		OP_NEW_CHAIN,
		OP_TAKE_SEED,
		OP_TAKE_BEST,
		OP_RD_AI,
		OP_CMP_AI,
		OP_REUSE,
		OP_GET_A,
		OP_GET_B,
		OP_PUSH,
		OP_RD_IB,
		OP_RD_BI,
		OP_CMP_IA,
		OP_SEED_I,
		OP_STEP1,
		OP_STEP2,
		OP_EMIT,
		OP_RD_ILO,
		OP_RD_LOI,
		OP_TMP_IHI,
		OP_TMP_HII,
		OP_MAX_NEXT,
		OP_SEED_HI
	} dp_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_INIT,
		ST_PASS,
		ST_NC_TAKE,
		ST_S_TEST,
		ST_S_CMP,
		ST_RU_A,
		ST_RU_B,
		ST_RU_T,
		ST_PUSH,
		ST_L1_TEST,
		ST_L1_CMP,
		ST_L2_TEST,
		ST_L2_CMP,
		ST_STEP2,
		ST_CHECK,
		ST_EMIT,
		ST_U1_TEST,
		ST_U1_TMP,
		ST_U1_MAX,
		ST_U2_TEST,
		ST_U2_TMP,
		ST_U2_MAX,
		ST_U3_TEST,
		ST_U3_TMP,
		ST_U3_MAX
	} ctrl_state_t;

	typedef struct packed {
		logic i_lt_n;
		logic i_lt_b;
		logic i_lt_lo;
		logic i_lt_hi;
		logic tip_le3;
		logic chain_match;
		logic run_done;
	} dp_status_t;

endpackage

`default_nettype wire

// File: rtl/nncl_ctrl.sv
// Sequencer for load, chain growth, merge and distance update phases.
// Depends on nncl_pkg for op codes, states and the status bundle.
`default_nettype none

module nncl_ctrl import nncl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        last_distance,
	input  dp_status_t  status,
	output dp_op_t      op,
	output logic        busy
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		op = OP_NONE;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					op = OP_LOAD;
					if (last_distance) state_d = ST_INIT;
				end
			end
			ST_INIT: begin
				op = OP_INIT;
				state_d = ST_PASS;
			end
			ST_PASS: begin
				if (status.tip_le3) begin
					op = OP_NEW_CHAIN;
					state_d = ST_NC_TAKE;
				end else begin
					op = OP_REUSE;
					state_d = ST_RU_A;
				end
			end
			ST_NC_TAKE: begin
				op = OP_TAKE_SEED;
				state_d = ST_S_TEST;
			end
			ST_S_TEST: begin
				if (status.i_lt_n) begin
					op = OP_RD_AI;
					state_d = ST_S_CMP;
				end else begin
					state_d = ST_PUSH;
				end
			end
			ST_S_CMP: begin
				op = OP_CMP_AI;
				state_d = ST_S_TEST;
			end
			ST_RU_A: begin
				op = OP_GET_A;
				state_d = ST_RU_B;
			end
			ST_RU_B: begin
				op = OP_GET_B;
				state_d = ST_RU_T;
			end
			ST_RU_T: begin
				op = OP_TAKE_BEST;
				state_d = ST_PUSH;
			end
			ST_PUSH: begin
				op = OP_PUSH;
				state_d = ST_L1_TEST;
			end
			ST_L1_TEST: begin
				if (status.i_lt_b) begin
					op = OP_RD_IB;
					state_d = ST_L1_CMP;
				end else begin
					op = OP_SEED_I;
					state_d = ST_L2_TEST;
				end
			end
			ST_L1_CMP: begin
				op = OP_CMP_IA;
				state_d = ST_L1_TEST;
			end
			ST_L2_TEST: begin
				if (status.i_lt_n) begin
					op = OP_RD_BI;
					state_d = ST_L2_CMP;
				end else begin
					op = OP_STEP1;
					state_d = ST_STEP2;
				end
			end
			ST_L2_CMP: begin
				op = OP_CMP_IA;
				state_d = ST_L2_TEST;
			end
			ST_STEP2: begin
				op = OP_STEP2;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				// reciprocal pair found when the new neighbour is the one below the tip
				state_d = status.chain_match ? ST_EMIT : ST_PUSH;
			end
			ST_EMIT: begin
				op = OP_EMIT;
				state_d = ST_U1_TEST;
			end
			ST_U1_TEST: begin
				if (status.i_lt_lo) begin
					op = OP_RD_ILO;
					state_d = ST_U1_TMP;
				end else begin
					state_d = ST_U2_TEST;
				end
			end
			ST_U1_TMP: begin
				op = OP_TMP_IHI;
				state_d = ST_U1_MAX;
			end
			ST_U1_MAX: begin
				op = OP_MAX_NEXT;
				state_d = ST_U1_TEST;
			end
			ST_U2_TEST: begin
				if (status.i_lt_hi) begin
					op = OP_RD_LOI;
					state_d = ST_U2_TMP;
				end else begin
					op = OP_SEED_HI;
					state_d = ST_U3_TEST;
				end
			end
			ST_U2_TMP: begin
				op = OP_TMP_IHI;
				state_d = ST_U2_MAX;
			end
			ST_U2_MAX: begin
				op = OP_MAX_NEXT;
				state_d = ST_U2_TEST;
			end
			ST_U3_TEST: begin
				if (status.i_lt_n) begin
					op = OP_RD_LOI;
					state_d = ST_U3_TMP;
				end else begin
					state_d = status.run_done ? ST_IDLE : ST_PASS;
				end
			end
			ST_U3_TMP: begin
				op = OP_TMP_HII;
				state_d = ST_U3_MAX;
			end
			ST_U3_MAX: begin
				op = OP_MAX_NEXT;
				state_d = ST_U3_TEST;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/nncl_dpath.sv
// Datapath: distance store, chain stack, active set, scan registers, result register.
// Executes one op per cycle from nncl_ctrl; depends on nncl_pkg.
`default_nettype none

module nncl_dpath import nncl_pkg::*; #(
	parameter int MAX_POINTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_op_t             op,
	input  dist_item_t         entry,
	input  logic               cfg_we,
	input  logic [CFG_W-1:0]   cfg_wdata,
	output dp_status_t         status,
	output logic               merge_strobe,
	output merge_item_t        merge
);

	localparam int IW = $clog2(MAX_POINTS);
	localparam int PW = $clog2(MAX_POINTS + 1);
	localparam int TW = PW + 1;
	localparam int DEPTH = MAX_POINTS * (MAX_POINTS - 1) / 2;
	localparam int AW = $clog2(DEPTH + 1);
	localparam int IXW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW = PW + 2;
	localparam int MW = SW + IW;

	logic [DIST_W-1:0] store [DEPTH];
	logic [IW-1:0]     chain [MAX_POINTS];

	logic [CFG_W-1:0]  pc_q;
	logic [PW-1:0]     n_q;
	logic [AW-1:0]     load_q;
	logic [MAX_POINTS-1:0] mask_q;
	logic [IW-1:0]     first_q;
	logic [PW-1:0]     i_q;
	logic [TW-1:0]     tip_q;
	logic [PW-1:0]     j_q;
	logic              strobe_q;

	logic [IW-1:0]     a_q, b_q;
	logic [DIST_W-1:0] best_q, tmp_q, st_rd_q;
	logic [IXW-1:0]    addr_q;
	logic [IW-1:0]     ch_rd_q;
	merge_item_t       merge_q;

	logic [IW-1:0]     lo, hi, ab_lo, ab_hi;
	logic [PW-1:0]     s_arg, s_out;
	logic [IW-1:0]     r_sel, c_sel;
	logic [SW-1:0]     row_span;
	logic [MW-1:0]     prod, slot_raw;
	logic [IXW-1:0]    rd_idx, wr_idx;
	logic              st_we;
	logic [DIST_W-1:0] wr_data;
	logic [TW-1:0]     ch_rd_raw, ch_wr_raw;
	logic [IW-1:0]     ch_rd_idx, ch_wr_idx, ch_wr_data;
	logic              ch_we;

	assign lo = (a_q < b_q) ? a_q : b_q;
	assign hi = (a_q < b_q) ? b_q : a_q;
	assign ab_lo = (a_q < ch_rd_q) ? a_q : ch_rd_q;
	assign ab_hi = (a_q < ch_rd_q) ? ch_rd_q : a_q;

	// successor in the active list; n when no active point lies above the argument and below n
	always_comb begin
		case (op)
			OP_NEW_CHAIN:              s_arg = PW'(first_q);
			OP_TAKE_SEED, OP_SEED_I:   s_arg = PW'(b_q);
			OP_EMIT:                   s_arg = PW'(lo);
			OP_SEED_HI:                s_arg = PW'(hi);
			default:                   s_arg = i_q;
		endcase
	end

	always_comb begin
		s_out = n_q;
		for (int k = MAX_POINTS - 1; k >= 0; k--) begin
			if (mask_q[k] && (PW'(k) > s_arg) && (PW'(k) < n_q)) s_out = PW'(k);
		end
	end

	// condensed index of (r, c) with r < c
	always_comb begin
		case (op)
			OP_NEW_CHAIN: begin r_sel = first_q;        c_sel = s_out[IW-1:0]; end
			OP_RD_AI:     begin r_sel = a_q;            c_sel = i_q[IW-1:0];   end
			OP_GET_B:     begin r_sel = ab_lo;          c_sel = ab_hi;         end
			OP_RD_IB:     begin r_sel = i_q[IW-1:0];    c_sel = b_q;           end
			OP_RD_BI:     begin r_sel = b_q;            c_sel = i_q[IW-1:0];   end
			OP_RD_ILO:    begin r_sel = i_q[IW-1:0];    c_sel = lo;            end
			OP_RD_LOI:    begin r_sel = lo;             c_sel = i_q[IW-1:0];   end
			OP_TMP_IHI:   begin r_sel = i_q[IW-1:0];    c_sel = hi;            end
			OP_TMP_HII:   begin r_sel = hi;             c_sel = i_q[IW-1:0];   end
			default:      begin r_sel = '0;             c_sel = '0;            end
		endcase
		row_span = SW'({n_q, 1'b0}) - SW'(3) - SW'(r_sel);
		prod = MW'(row_span) * MW'(r_sel);
		slot_raw = (prod >> 1) + MW'(c_sel) - MW'(1);
		if (slot_raw > MW'(DEPTH - 1)) begin
			rd_idx = IXW'(DEPTH - 1);
		end else begin
			rd_idx = slot_raw[IXW-1:0];
		end
	end

	always_comb begin
		st_we = 1'b0;
		wr_idx = addr_q;
		wr_data = tmp_q;
		case (op)
			OP_LOAD: begin
				st_we = (load_q < AW'(DEPTH));
				wr_idx = load_q[IXW-1:0];
				wr_data = entry.distance;
			end
			OP_MAX_NEXT: begin
				st_we = (st_rd_q < tmp_q);
			end
			default: begin
				st_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_we) store[wr_idx] <= wr_data;
		st_rd_q <= store[rd_idx];
		addr_q <= rd_idx;
	end

	// chain stack; index clamps at the last entry
	always_comb begin
		case (op)
			OP_REUSE: ch_rd_raw = tip_q - TW'(REUSE_DEPTH + 1);
			OP_STEP2: ch_rd_raw = tip_q - TW'(1);
			default:  ch_rd_raw = tip_q;
		endcase
		ch_rd_idx = (ch_rd_raw >= TW'(MAX_POINTS)) ? IW'(MAX_POINTS - 1) : ch_rd_raw[IW-1:0];
		ch_we = (op == OP_NEW_CHAIN) || (op == OP_PUSH);
		ch_wr_raw = (op == OP_NEW_CHAIN) ? '0 : tip_q;
		ch_wr_idx = (ch_wr_raw >= TW'(MAX_POINTS)) ? IW'(MAX_POINTS - 1) : ch_wr_raw[IW-1:0];
		ch_wr_data = (op == OP_NEW_CHAIN) ? first_q : b_q;
	end

	always_ff @(posedge clk) begin
		if (ch_we) chain[ch_wr_idx] <= ch_wr_data;
		ch_rd_q <= chain[ch_rd_idx];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= CFG_W'(PC_RESET);
			n_q <= PW'(MAX_POINTS);
			load_q <= '0;
			mask_q <= '0;
			first_q <= '0;
			i_q <= '0;
			tip_q <= '0;
			j_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			if (cfg_we) pc_q <= cfg_wdata;
			strobe_q <= (op == OP_EMIT);
			case (op)
				OP_LOAD: begin
					if (load_q < AW'(DEPTH)) load_q <= load_q + AW'(1);
				end
				OP_INIT: begin
					if (pc_q < CFG_W'(2)) begin
						n_q <= PW'(2);
					end else if ((CFG_W + 1)'(pc_q) > (CFG_W + 1)'(MAX_POINTS)) begin
						n_q <= PW'(MAX_POINTS);
					end else begin
						n_q <= PW'(pc_q);
					end
					load_q <= '0;
					mask_q <= '1;
					first_q <= '0;
					tip_q <= '0;
					j_q <= '0;
				end
				OP_NEW_CHAIN: tip_q <= TW'(1);
				OP_TAKE_SEED, OP_SEED_I, OP_SEED_HI: i_q <= s_out;
				OP_CMP_AI, OP_CMP_IA, OP_MAX_NEXT: i_q <= s_out;
				OP_REUSE: tip_q <= tip_q - TW'(REUSE_DEPTH);
				OP_PUSH: i_q <= PW'(first_q);
				OP_STEP2: tip_q <= tip_q + TW'(1);
				OP_EMIT: begin
					mask_q[lo] <= 1'b0;
					if (lo == first_q) begin
						first_q <= s_out[IW-1:0];
						i_q <= s_out;
					end else begin
						i_q <= PW'(first_q);
					end
					j_q <= j_q + PW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// scan payload
	always_ff @(posedge clk) begin
		case (op)
			OP_NEW_CHAIN: begin
				a_q <= first_q;
				b_q <= s_out[IW-1:0];
			end
			OP_TAKE_SEED, OP_TAKE_BEST: best_q <= st_rd_q;
			OP_CMP_AI: begin
				if (st_rd_q < best_q) begin
					best_q <= st_rd_q;
					b_q <= i_q[IW-1:0];
				end
			end
			OP_CMP_IA: begin
				if (st_rd_q < best_q) begin
					best_q <= st_rd_q;
					a_q <= i_q[IW-1:0];
				end
			end
			OP_GET_A: a_q <= ch_rd_q;
			OP_GET_B: b_q <= ch_rd_q;
			OP_STEP1: b_q <= a_q;
			OP_STEP2: a_q <= ch_rd_q;
			OP_TMP_IHI, OP_TMP_HII: tmp_q <= st_rd_q;
			OP_EMIT: begin
				merge_q.first_point <= PT_W'(a_q);
				merge_q.second_point <= PT_W'(b_q);
				merge_q.merge_distance <= best_q;
				merge_q.final_merge <= (j_q == n_q - PW'(2));
			end
			default: begin
			end
		endcase
	end

	assign status.i_lt_n = (i_q < n_q);
	assign status.i_lt_b = (i_q < PW'(b_q));
	assign status.i_lt_lo = (i_q < PW'(lo));
	assign status.i_lt_hi = (i_q < PW'(hi));
	assign status.tip_le3 = (tip_q <= TW'(REUSE_DEPTH));
	assign status.chain_match = (b_q == ch_rd_q);
	assign status.run_done = (j_q == n_q - PW'(1));

	assign merge_strobe = strobe_q;
	assign merge = merge_q;

endmodule

`default_nettype wire

// File: rtl/nn_chain_complete_linkage_unit.sv
// Top level: complete-linkage clustering by nearest-neighbour chain.
// Instantiates nncl_ctrl and nncl_dpath; depends on nncl_pkg.
//
//  channel   handshake              payload
//  load      start / busy           entry  (dist_item_t)
//  result    merge_strobe           merge  (merge_item_t)
//  config    cfg_we                 cfg_wdata (point count)
//
// Distance items load while start is high and busy is low, and may follow back to back.
// The item marked last starts the pass, which holds busy high until all merges
// and distance updates are done; candidate scans and updates all go through the
// single read port of the distance store.
// No clearing pass after reset. Results cannot be stalled; each is shown for one cycle.
`default_nettype none

module nn_chain_complete_linkage_unit import nncl_pkg::*; #(
	parameter int MAX_POINTS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  dist_item_t        entry,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_wdata,
	output logic              merge_strobe,
	output merge_item_t       merge
);

	dp_op_t     op;
	dp_status_t status;

	nncl_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.last_distance (entry.last_distance),
		.status        (status),
		.op            (op),
		.busy          (busy)
	);

	nncl_dpath #(
		.MAX_POINTS (MAX_POINTS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.entry        (entry),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.status       (status),
		.merge_strobe (merge_strobe),
		.merge        (merge)
	);

	// a merge only appears while a pass runs
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		merge_strobe |-> busy) else $error("merge outside a pass");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !merge_strobe) else $error("merge after idle");

	a_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		merge_strobe |-> (merge.first_point != merge.second_point))
		else $error("merge of a cluster with itself");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Testbench for nn_chain_complete_linkage_unit: loads distance matrices, checks each merge.
// The expected merges come from a clustering predictor kept inside this file.
// Depends on nncl_pkg and the RTL of the unit.
`timescale 1ns / 100ps

module tb_top;
	import nncl_pkg::*;

	localparam int NPTS = 64;
	localparam int DEPTH = NPTS * (NPTS - 1) / 2;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	dist_item_t  entry;
	logic        cfg_we;
	logic [CFG_W-1:0] cfg_wdata;
	logic        merge_strobe;
	merge_item_t merge;

	nn_chain_complete_linkage_unit #(.MAX_POINTS(NPTS)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .entry(entry),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .merge_strobe(merge_strobe), .merge(merge)
	);

	// predictor state
	logic [DIST_W-1:0] mat_q[DEPTH];
	int unsigned load_pos_q;
	int unsigned chain_q[NPTS];
	int unsigned tip_q;
	int unsigned next_q[NPTS+1];
	int unsigned prev_q[NPTS+1];
	int unsigned head_q;
	int unsigned count_reg;
	int unsigned run_pts;
	int unsigned filled;        // entries of the store written at least once
	merge_item_t pending_merges[$];

	int errors;
	int sender_idle_pct;
	int random_items;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned eff_points();
		if (count_reg < 2) return 2;
		if (count_reg > NPTS) return NPTS;
		return count_reg;
	endfunction

	function automatic int unsigned cell_at(int unsigned r, int unsigned c);
		int unsigned idx;
		idx = (((2 * run_pts - 3 - r) * r) >> 1) + c - 1;
		return idx < DEPTH ? idx : DEPTH - 1;
	endfunction

	function automatic int unsigned dist_of(int unsigned r, int unsigned c);
		return mat_q[cell_at(r, c)];
	endfunction

	function automatic void raise_to(int unsigned r, int unsigned c, int unsigned v);
		int unsigned s;
		s = cell_at(r, c);
		if (mat_q[s] < v) mat_q[s] = v;
	endfunction

	function automatic int unsigned nxt(int unsigned i);
		return next_q[i <= NPTS ? i : NPTS];
	endfunction

	function automatic int unsigned chain_rd(int unsigned t);
		return chain_q[t < NPTS ? t : NPTS - 1];
	endfunction

	function automatic void chain_wr(int unsigned t, int unsigned v);
		chain_q[t < NPTS ? t : NPTS - 1] = v;
	endfunction

	function automatic void retire(int unsigned x);
		int unsigned nx, p;
		nx = nxt(x);
		if (x == head_q) begin
			head_q = nx;
		end else begin
			p = prev_q[x] <= NPTS ? prev_q[x] : 0;
			next_q[p] = nx;
			if (nx <= NPTS) prev_q[nx] = p;
		end
		next_q[x] = 0;
	endfunction

	// complete-linkage nearest-neighbour chain; queues every merge it makes
	function automatic void predict_clustering();
		int unsigned n, i, j, a, b, lo, hi, best;
		merge_item_t m;
		n = eff_points();
		run_pts = n;
		for (i = 0; i <= NPTS; i++) begin
			next_q[i] = i + 1;
			prev_q[i] = i ? i - 1 : 0;
		end
		head_q = 0;
		tip_q = 0;
		for (j = 0; j + 1 < n; j++) begin
			if (tip_q <= REUSE_DEPTH) begin
				a = head_q;
				chain_wr(0, a);
				tip_q = 1;
				b = nxt(a);
				best = dist_of(a, b);
				for (i = nxt(b); i < n; i = nxt(i))
					if (dist_of(a, i) < best) begin
						best = dist_of(a, i);
						b = i;
					end
			end else begin
				tip_q -= REUSE_DEPTH;
				a = chain_rd(tip_q - 1);
				b = chain_rd(tip_q);
				best = a < b ? dist_of(a, b) : dist_of(b, a);
			end
			do begin
				chain_wr(tip_q, b);
				for (i = head_q; i < b; i = nxt(i))
					if (dist_of(i, b) < best) begin
						best = dist_of(i, b);
						a = i;
					end
				for (i = nxt(b); i < n; i = nxt(i))
					if (dist_of(b, i) < best) begin
						best = dist_of(b, i);
						a = i;
					end
				b = a;
				a = chain_rd(tip_q);
				tip_q++;
			end while (b != chain_rd(tip_q - 2));

			m.first_point = a[PT_W-1:0];
			m.second_point = b[PT_W-1:0];
			m.merge_distance = best[DIST_W-1:0];
			m.final_merge = (j + 2 == n);
			pending_merges.push_back(m);

			lo = a < b ? a : b;
			hi = a < b ? b : a;
			retire(lo);
			for (i = head_q; i < lo; i = nxt(i)) raise_to(i, hi, dist_of(i, lo));
			for (; i < hi; i = nxt(i)) raise_to(i, hi, dist_of(lo, i));
			for (i = nxt(hi); i < n; i = nxt(i)) raise_to(hi, i, dist_of(lo, i));
		end
	endfunction

	// send one item; start stays high afterwards unless a gap follows or it was last
	task automatic send_item(input logic [DIST_W-1:0] d, input logic last);
		int gap;
		start <= 1'b1;
		entry <= '{distance: d, last_distance: last};
		do @(posedge clk); while (busy);
		if (load_pos_q < DEPTH) begin
			mat_q[load_pos_q] = d;
			load_pos_q++;
			if (load_pos_q > filled) filled = load_pos_q;
		end
		if (last) begin
			predict_clustering();
			load_pos_q = 0;
		end
		gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(1, 4) : 0;
		// start drops after the last item, even when no random gap was drawn
		if (last && gap == 0) gap = 1;
		if (last || gap > 0) start <= 1'b0;
		repeat (gap) @(posedge clk);
	endtask

	task automatic write_count(input int unsigned v);
		while (pending_merges.size() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v[CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		count_reg = v;
	endtask

	// one matrix load of k items; mode 0 full range, 1 small values (many ties)
	task automatic load_matrix(input int unsigned k, input int mode);
		int unsigned i;
		logic [DIST_W-1:0] d;
		for (i = 0; i < k; i++) begin
			d = mode ? DIST_W'($urandom_range(0, 7)) : DIST_W'($urandom);
			send_item(d, i + 1 == k);
		end
	endtask

	task automatic test_small_sizes();
		write_count(2);
		send_item(16'h0000, 1'b1);
		send_item(16'hFFFF, 1'b1);
		write_count(0);              // behaves as two points
		send_item(16'h1234, 1'b1);
		write_count(1);
		send_item(16'h8001, 1'b1);
		write_count(3);              // all equal: ties keep earlier candidate
		repeat (2) send_item(16'd5, 1'b0);
		send_item(16'd5, 1'b1);
		send_item(16'hFFFF, 1'b0);   // extra entries beyond the triangle are ignored
		send_item(16'h0000, 1'b0);
		send_item(16'h7FFF, 1'b0);
		send_item(16'h0001, 1'b0);
		send_item(16'hAAAA, 1'b1);
		write_count(4);
		send_item(16'h0000, 1'b0);
		send_item(16'hFFFF, 1'b0);
		send_item(16'h0001, 1'b0);
		send_item(16'hFFFE, 1'b0);
		send_item(16'h8000, 1'b0);
		send_item(16'h5555, 1'b1);
		send_item(16'h0003, 1'b1);   // early last mark: rest keeps merged values
	endtask

	task automatic test_full_size();
		int unsigned i;
		write_count(NPTS);
		// run past the store depth so the overflow items are dropped
		for (i = 0; i < DEPTH + 3; i++)
			send_item(DIST_W'($urandom), i + 1 == DEPTH + 3);
		write_count(127);
		load_matrix(6, 0);
		write_count(NPTS + 1);
		load_matrix(1, 1);
	endtask

	task automatic test_random_runs();
		int unsigned n, need, k, v;
		random_items = 0;
		while (random_items < 410) begin
			sender_idle_pct = random_items < 137 ? 20 : (random_items < 274 ? 46 : 0);
			v = $urandom_range(99);
			if (v < 4) n = $urandom_range(0, 1);
			else if (v < 8) n = $urandom_range(NPTS + 1, 127);
			else if (v < 80) n = $urandom_range(2, 10);
			else n = $urandom_range(11, 20);
			write_count(n);
			need = eff_points() * (eff_points() - 1) / 2;
			v = $urandom_range(99);
			if (need > 200) k = $urandom_range(1, 8);
			else if (v < 10) k = need + $urandom_range(1, 3);
			else if (v < 20) k = $urandom_range(1, need);
			else k = need;
			if (k < need && filled < need) k = need;
			load_matrix(k, $urandom_range(1));
			random_items += k;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && merge_strobe) begin
			if (pending_merges.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected merge %p", merge);
			end else begin
				if (merge !== pending_merges[0]) begin
					errors++;
					if (errors <= 10)
						$display("merge mismatch: expected %p got %p",
							pending_merges[0], merge);
				end
				void'(pending_merges.pop_front());
			end
		end
	end

	initial begin
		#50ms;
		$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		errors = 0;
		filled = 0;
		load_pos_q = 0;
		count_reg = PC_RESET;
		sender_idle_pct = 20;
		start = 1'b0;
		entry = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_small_sizes();
		test_full_size();
		test_random_runs();

		while (pending_merges.size() != 0 || busy) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0 && pending_merges.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

// File: filelist.f
rtl/nncl_pkg.sv
rtl/nncl_ctrl.sv
rtl/nncl_dpath.sv
rtl/nn_chain_complete_linkage_unit.sv
tb/tb_top.sv
